### hw/rtl/assert_macros.svh
// assertion macros used by the checker file pwft_checker
// needs signals clk and rst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/pwft_pkg.sv
// types, register indexes and reset values of the pulse width frame transmitter
// used by every module of the block, depends on nothing
`default_nettype none

package pwft_pkg;

  localparam int FRAME_BYTES = 4;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int POS_W       = $clog2(FRAME_BITS);
  localparam int TICK_W      = 8;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_PAD_W   = 5;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC     = 3'd4;

  // reset values
  localparam logic [TICK_W-1:0] RST_SHORT    = 8'd2;
  localparam logic [TICK_W-1:0] RST_LONG     = 8'd6;
  localparam logic [TICK_W-1:0] RST_PREAMBLE = 8'd10;
  localparam logic [TICK_W-1:0] RST_TRAILER  = 8'd3;
  localparam logic [BYTE_W-1:0] RST_SYNC     = 8'hBA;

  // input command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_PRE   = 5'b00010,
    PH_LOW   = 5'b00100,
    PH_HIGH  = 5'b01000,
    PH_TRAIL = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] preamble_ticks;
    logic [TICK_W-1:0] trailer_ticks;
    logic [BYTE_W-1:0] sync_byte;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_ignored;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/pwft_cfg.sv
// configuration register file of the pulse width frame transmitter
// depends on pwft_pkg
`default_nettype none

module pwft_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [pwft_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [pwft_pkg::BYTE_W-1:0]    wr_data,
  output pwft_pkg::cfg_t                     cfg
);

  pwft_pkg::cfg_t cfg_r;
  pwft_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        pwft_pkg::CFG_SHORT:    cfg_nxt.short_ticks    = wr_data;
        pwft_pkg::CFG_LONG:     cfg_nxt.long_ticks     = wr_data;
        pwft_pkg::CFG_PREAMBLE: cfg_nxt.preamble_ticks = wr_data;
        pwft_pkg::CFG_TRAILER:  cfg_nxt.trailer_ticks  = wr_data;
        pwft_pkg::CFG_SYNC:     cfg_nxt.sync_byte      = wr_data;
        default:                cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ticks    <= pwft_pkg::RST_SHORT;
      cfg_r.long_ticks     <= pwft_pkg::RST_LONG;
      cfg_r.preamble_ticks <= pwft_pkg::RST_PREAMBLE;
      cfg_r.trailer_ticks  <= pwft_pkg::RST_TRAILER;
      cfg_r.sync_byte      <= pwft_pkg::RST_SYNC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### hw/rtl/pwft_core.sv
// frame sequencer: phase, tick counter, bit position and frame word state
// one word per cycle while en is high; depends on pwft_pkg
`default_nettype none

module pwft_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       cmd,
  input  wire logic [pwft_pkg::BYTE_W-1:0] sensor_index,
  input  wire logic [pwft_pkg::BYTE_W-1:0] temperature,
  input  wire pwft_pkg::cfg_t             cfg,
  output pwft_pkg::res_t                  res
);

  pwft_pkg::phase_t                  phase_r, phase_nxt;
  logic [pwft_pkg::TICK_W-1:0]       tick_r, tick_nxt;
  logic [pwft_pkg::POS_W-1:0]        pos_r, pos_nxt, pos_inc;
  logic [pwft_pkg::FRAME_BITS-1:0]   bits_r, bits_nxt;
  logic                              line_r, line_nxt;
  logic                              busy, busy_nxt, tick_end;
  logic                              bit_cur, bit_inc, done, ignored;

  assign busy     = phase_r inside {pwft_pkg::PH_PRE, pwft_pkg::PH_LOW,
                                    pwft_pkg::PH_HIGH, pwft_pkg::PH_TRAIL};
  assign busy_nxt = phase_nxt inside {pwft_pkg::PH_PRE, pwft_pkg::PH_LOW,
                                      pwft_pkg::PH_HIGH, pwft_pkg::PH_TRAIL};
  assign pos_inc  = pos_r + pwft_pkg::POS_W'(1);
  assign bit_cur  = bits_r[pos_r];
  assign bit_inc  = bits_r[pos_inc];
  assign tick_end = (tick_r <= pwft_pkg::TICK_W'(1));

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    pos_nxt   = pos_r;
    bits_nxt  = bits_r;
    line_nxt  = line_r;
    done      = 1'b0;
    ignored   = 1'b0;
    if (cmd == pwft_pkg::CMD_START) begin
      if (busy) begin
        ignored = 1'b1;
      end else begin
        bits_nxt  = {temperature, sensor_index, cfg.sync_byte, cfg.sync_byte};
        pos_nxt   = '0;
        phase_nxt = pwft_pkg::PH_PRE;
        line_nxt  = 1'b1;
        tick_nxt  = cfg.preamble_ticks;
      end
    end else if (busy) begin
      tick_nxt = tick_end ? '0 : tick_r - pwft_pkg::TICK_W'(1);
      if (tick_end) begin
        case (phase_r)
          pwft_pkg::PH_PRE: begin
            phase_nxt = pwft_pkg::PH_LOW;
            line_nxt  = 1'b0;
            tick_nxt  = bit_cur ? cfg.short_ticks : cfg.long_ticks;
          end
          pwft_pkg::PH_LOW: begin
            phase_nxt = pwft_pkg::PH_HIGH;
            line_nxt  = 1'b1;
            tick_nxt  = bit_cur ? cfg.long_ticks : cfg.short_ticks;
          end
          pwft_pkg::PH_HIGH: begin
            if (pos_r == pwft_pkg::LAST_POS) begin
              phase_nxt = pwft_pkg::PH_TRAIL;
              line_nxt  = 1'b1;
              tick_nxt  = cfg.trailer_ticks;
            end else begin
              pos_nxt   = pos_inc;
              phase_nxt = pwft_pkg::PH_LOW;
              line_nxt  = 1'b0;
              tick_nxt  = bit_inc ? cfg.short_ticks : cfg.long_ticks;
            end
          end
          default: begin
            phase_nxt = pwft_pkg::PH_IDLE;
            line_nxt  = 1'b0;
            tick_nxt  = '0;
            pos_nxt   = '0;
            done      = 1'b1;
          end
        endcase
      end
    end else begin
      phase_nxt = pwft_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pwft_pkg::PH_IDLE;
      tick_r  <= '0;
      pos_r   <= '0;
      line_r  <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bits_r <= bits_nxt;
    end
  end

  // line_level, busy_res, frame_done, start_ignored from the top bit down
  assign res = {line_nxt, busy_nxt, done, ignored};

endmodule

`default_nettype wire

### hw/rtl/pulse_width_frame_transmitter_unit.sv
// a word accepted into the input register reaches the output through the result register
// throughput: one word per cycle while the receiver takes results, set by the sequencer update
// the input register takes a new word while the result register waits, if it is empty
// reset: synchronous active-low rst_n clears the sequencer to idle with the
// line low and loads the default tick counts and sync byte
`default_nettype none

module pulse_width_frame_transmitter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [15:0]                   in_tdata,  // sensor_index, temperature
  input  wire logic                          in_tuser,  // cmd
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [7:0]                    out_tdata, // line_level, busy_res, start_ignored
  output      logic                          out_tlast, // frame_done
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [pwft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pwft_pkg::BYTE_W-1:0]    cfg_data
);

  pwft_pkg::cfg_t                 cfg;
  pwft_pkg::res_t                 res;
  logic                           in_valid_r, in_valid_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           cmd_r;
  logic [pwft_pkg::BYTE_W-1:0]    sensor_r, temp_r;
  logic                           line_r, busy_r, done_r, ign_r;
  logic                           adv, in_acc, step;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign step      = in_valid_r && adv;

  assign in_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : in_valid_r);
  assign out_valid_nxt = adv ? in_valid_r : out_valid_r;

  pwft_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pwft_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (step),
    .cmd          (cmd_r),
    .sensor_index (sensor_r),
    .temperature  (temp_r),
    .cfg          (cfg),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_tuser;
      sensor_r <= in_tdata[7:0];
      temp_r   <= in_tdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      line_r <= res.line_level;
      busy_r <= res.busy_res;
      done_r <= res.frame_done;
      ign_r  <= res.start_ignored;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{pwft_pkg::OUT_PAD_W{1'b0}}, ign_r, busy_r, line_r};
  assign out_tlast  = done_r;

endmodule

`default_nettype wire

### hw/rtl/pwft_checker.sv
// port-level checks of the pulse width frame transmitter and their bind
// depends on assert_macros.svh and the top level
`default_nettype none
`include "assert_macros.svh"

module pwft_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // frame end leaves the line low and the sequencer idle
  `AST_IMP(a_done_idle, out_tvalid && out_tlast, !out_tdata[0] && !out_tdata[1])
  // a dropped start only happens during a frame
  `AST_IMP(a_ign_busy, out_tvalid && out_tdata[2], out_tdata[1])
  // line is low whenever no frame is running
  `AST_IMP(a_idle_low, out_tvalid && !out_tdata[1], !out_tdata[0])
  // stalled word holds
  `AST_NXT(a_out_hold, out_tvalid && !out_tready,
           out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind pulse_width_frame_transmitter_unit pwft_checker u_pwft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### verif/pwft_line_checker.sv
// result checker for the pulse width frame transmitter: tracks the register and
// input words it sees, predicts every result word and compares them in order
// depends on pwft_pkg for phase codes, register indexes and reset values
module pwft_line_checker
  import pwft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [15:0]          in_tdata,   // sensor_index, temperature
  input  logic                 in_tuser,   // cmd
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,  // line_level, busy_res, start_ignored
  input  logic                 out_tlast,  // frame_done
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   words_pending,
  output int                   frames_finished,
  output int                   starts_dropped
);

  cfg_t                  tick_cfg;
  phase_t                seq_phase;
  logic [TICK_W-1:0]     ticks_left;
  logic [POS_W-1:0]      bit_idx;
  logic [FRAME_BITS-1:0] frame_word;
  logic                  line_hi;
  res_t                  line_q[$];
  int                    bad;
  int                    checked;
  int                    done_cnt;
  int                    drop_cnt;

  task automatic report_mismatch(input string what, input int got, input int want);
    bad++;
    if (bad <= 25)
      $display("result word %0d: %s is %0d, predicted %0d", checked, what, got, want);
  endtask

  function automatic logic [TICK_W-1:0] low_span(input logic b);
    return b ? tick_cfg.short_ticks : tick_cfg.long_ticks;
  endfunction

  function automatic logic [TICK_W-1:0] high_span(input logic b);
    return b ? tick_cfg.long_ticks : tick_cfg.short_ticks;
  endfunction

  task automatic predict_word(input logic cmd, input logic [7:0] sensor,
                              input logic [7:0] temp);
    res_t r;
    logic busy;
    r = '0;
    busy = (seq_phase != PH_IDLE);
    if (cmd == CMD_START) begin
      if (busy) begin
        r.start_ignored = 1'b1;
        drop_cnt++;
      end else begin
        frame_word = {temp, sensor, tick_cfg.sync_byte, tick_cfg.sync_byte};
        bit_idx    = '0;
        seq_phase  = PH_PRE;
        line_hi    = 1'b1;
        ticks_left = tick_cfg.preamble_ticks;
      end
    end else if (busy) begin
      if (ticks_left <= 1) begin
        ticks_left = '0;
        case (seq_phase)
          PH_PRE: begin
            seq_phase  = PH_LOW;
            line_hi    = 1'b0;
            ticks_left = low_span(frame_word[bit_idx]);
          end
          PH_LOW: begin
            seq_phase  = PH_HIGH;
            line_hi    = 1'b1;
            ticks_left = high_span(frame_word[bit_idx]);
          end
          PH_HIGH: begin
            if (bit_idx == LAST_POS) begin
              seq_phase  = PH_TRAIL;
              line_hi    = 1'b1;
              ticks_left = tick_cfg.trailer_ticks;
            end else begin
              bit_idx    = bit_idx + 1'b1;
              seq_phase  = PH_LOW;
              line_hi    = 1'b0;
              ticks_left = low_span(frame_word[bit_idx]);
            end
          end
          default: begin
            seq_phase    = PH_IDLE;
            line_hi      = 1'b0;
            bit_idx      = '0;
            r.frame_done = 1'b1;
            done_cnt++;
          end
        endcase
      end else begin
        ticks_left = ticks_left - 1'b1;
      end
    end
    r.line_level = line_hi;
    r.busy_res   = (seq_phase != PH_IDLE);
    line_q.push_back(r);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      line_q.delete();
      tick_cfg   = '{RST_SHORT, RST_LONG, RST_PREAMBLE, RST_TRAILER, RST_SYNC};
      seq_phase  = PH_IDLE;
      ticks_left = '0;
      bit_idx    = '0;
      frame_word = '0;
      line_hi    = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (line_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = line_q.pop_front();
          if (out_tdata[0] !== want.line_level)
            report_mismatch("line_level", out_tdata[0], want.line_level);
          if (out_tdata[1] !== want.busy_res)
            report_mismatch("busy_res", out_tdata[1], want.busy_res);
          if (out_tdata[2] !== want.start_ignored)
            report_mismatch("start_ignored", out_tdata[2], want.start_ignored);
          if (out_tlast !== want.frame_done)
            report_mismatch("frame_done", out_tlast, want.frame_done);
          if (out_tdata[7:3] !== '0)
            report_mismatch("tdata padding", out_tdata[7:3], 0);
        end
        checked++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHORT:    tick_cfg.short_ticks    = cfg_data;
          CFG_LONG:     tick_cfg.long_ticks     = cfg_data;
          CFG_PREAMBLE: tick_cfg.preamble_ticks = cfg_data;
          CFG_TRAILER:  tick_cfg.trailer_ticks  = cfg_data;
          CFG_SYNC:     tick_cfg.sync_byte      = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_word(in_tuser, in_tdata[7:0], in_tdata[15:8]);
    end
    mismatches      <= bad;
    words_pending   <= line_q.size();
    frames_finished <= done_cnt;
    starts_dropped  <= drop_cnt;
  end

endmodule

### verif/pulse_width_frame_transmitter_unit_test.sv
// testbench top for pulse_width_frame_transmitter_unit: drives register and
// command words with bursty timing and a stalling receiver, gives the verdict
// depends on pwft_pkg, the block and pwft_line_checker
module pulse_width_frame_transmitter_unit_test;
  import pwft_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_WORDS   = 150;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // sensor_index, temperature
  logic                 in_tuser   = 1'b0; // cmd
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // line_level, busy_res, start_ignored
  logic                 out_tlast;         // frame_done
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;

  int errors;
  int pending;
  int frames_seen;
  int drops_seen;

  logic [7:0] set_short    = RST_SHORT;
  logic [7:0] set_long     = RST_LONG;
  logic [7:0] set_preamble = RST_PREAMBLE;
  logic [7:0] set_trailer  = RST_TRAILER;
  int         settings_used = 1;
  int         words_sent;
  int         burst_left;

  int results_seen;
  int hold_left;
  int mode_left;
  int stall_mode;
  bit held_once;
  int quiet_cycles;

  pulse_width_frame_transmitter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pwft_line_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (errors),
    .words_pending   (pending),
    .frames_finished (frames_seen),
    .starts_dropped  (drops_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: changing stall modes, one long hold-off partway through
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        results_seen <= results_seen + 1;
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left  <= $urandom_range(16, 128);
          stall_mode <= $urandom_range(0, 2);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int span_of(input logic [7:0] ticks);
    return (ticks == 0) ? 1 : ticks;
  endfunction

  function automatic int frame_span();
    return span_of(set_preamble) + FRAME_BITS * (span_of(set_short) + span_of(set_long)) +
           span_of(set_trailer);
  endfunction

  function automatic logic [7:0] rand_ticks();
    return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
  endfunction

  task automatic send_word(input logic cmd, input logic [7:0] sensor, input logic [7:0] temp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {temp, sensor};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic pause_sender();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] s, input logic [7:0] l, input logic [7:0] p,
                             input logic [7:0] t, input logic [7:0] sync);
    set_short    = s;
    set_long     = l;
    set_preamble = p;
    set_trailer  = t;
    write_reg(CFG_SHORT, s);
    write_reg(CFG_LONG, l);
    write_reg(CFG_PREAMBLE, p);
    write_reg(CFG_TRAILER, t);
    write_reg(CFG_SYNC, sync);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // one start, then exactly the ticks the frame needs, with stray starts mixed in when noisy
  task automatic run_frame(input logic [7:0] sensor, input logic [7:0] temp, input bit noisy);
    int span;
    span = frame_span();
    send_word(CMD_START, sensor, temp);
    for (int i = 0; i < span; i++) begin
      if (noisy && $urandom_range(0, 31) == 0)
        send_word(CMD_START, 8'($urandom), 8'($urandom));
      send_word(CMD_TICK, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int random_base;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_TICK, 8'hFF, 8'h7F);
    send_word(CMD_TICK, 8'h00, 8'h80);
    send_word(CMD_START, 8'h00, 8'h80);
    send_word(CMD_START, 8'hFF, 8'h7F);
    repeat (frame_span()) send_word(CMD_TICK, 8'h00, 8'h00);
    run_frame(8'hFF, 8'h7F, 1'b1);
    send_word(CMD_TICK, 8'hA5, 8'h5A);

    pause_sender();
    load_config(8'd1, 8'd1, 8'd1, 8'd1, 8'h00);
    run_frame(8'h5A, 8'hA5, 1'b1);

    pause_sender();
    write_reg(CFG_UNUSED, 8'h01);
    load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'hFF);
    run_frame(8'hFF, 8'h80, 1'b1);

    pause_sender();
    load_config(8'd1, 8'd1, 8'd255, 8'd1, 8'h55);
    run_frame(8'h81, 8'h01, 1'b1);

    random_base = words_sent;
    while (words_sent - random_base < RANDOM_WORDS) begin
      pause_sender();
      load_config(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(), 8'($urandom));
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 3)) send_word(CMD_TICK, 8'($urandom), 8'($urandom));
        run_frame(8'($urandom), 8'($urandom), 1'b1);
      end
    end
    pause_sender();

    $display("sent %0d words over %0d register settings", words_sent, settings_used);
    $display("%0d frames finished, %0d starts dropped while busy", frames_seen, drops_seen);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
